@@ rtl/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// twc_pkg
// Shared constants, payload types and memory port types for the trie word
// counter.
// ----------------------------------------------------------------------------
package twc_pkg;

   localparam int NODES     = 1024;
   localparam int ALPHABET  = 26;
   localparam int NODE_W    = $clog2(NODES);
   localparam int USED_W    = $clog2(NODES + 1);
   localparam int LANE_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int LETTER_W  = 5;
   localparam int COUNT_W   = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [LANE_W-1:0] lane_type;

   // One trie node: a child link for every letter of the alphabet.
   typedef logic [ALPHABET-1:0][NODE_W-1:0] child_row_type;

   typedef struct packed {
      logic                func;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic     en;
      logic     clear;
      node_type row;
      lane_type lane;
      node_type data;
   } child_wr_type;

   typedef struct packed {
      logic               en;
      node_type           addr;
      logic [COUNT_W-1:0] data;
   } count_wr_type;

endpackage

@@ rtl/twc_child_mem.sv @@
// ----------------------------------------------------------------------------
// twc_child_mem
// Child link store, one row per trie node. A write either clears a whole
// row or updates a single letter lane; a read returns the whole row from
// an output register.
// ----------------------------------------------------------------------------
module twc_child_mem (
   input  logic                  clock,
   input  logic                  rd_en,
   input  twc_pkg::node_type     rd_row,
   output twc_pkg::child_row_type rd_data,
   input  twc_pkg::child_wr_type wr
);

   twc_pkg::child_row_type store_ff [twc_pkg::NODES];
   twc_pkg::child_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int k = 0; k < twc_pkg::ALPHABET; k++) begin
            if (wr.clear) begin
               store_ff[wr.row][k] <= '0;
            end else if (wr.lane == twc_pkg::LANE_W'(k)) begin
               store_ff[wr.row][k] <= wr.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/twc_count_mem.sv @@
// ----------------------------------------------------------------------------
// twc_count_mem
// Word count store, one entry per trie node, with a registered read port
// and a separate write port.
// ----------------------------------------------------------------------------
module twc_count_mem (
   input  logic                         clock,
   input  logic                         rd_en,
   input  twc_pkg::node_type            rd_addr,
   output logic [twc_pkg::COUNT_W-1:0]  rd_data,
   input  twc_pkg::count_wr_type        wr
);

   logic [twc_pkg::COUNT_W-1:0] store_ff [twc_pkg::NODES];
   logic [twc_pkg::COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/trie_word_counter.sv @@
// ----------------------------------------------------------------------------
// trie_word_counter
// Prefix trie over a letter alphabet with per-word occurrence counts. Words
// arrive one letter per transaction; the last letter of a word returns its
// count and the pool-full status.
// ----------------------------------------------------------------------------
// Sequencing: a letter passes S_IDLE, where it is accepted and its child row
// read starts, then S_LOOK (link follow or allocate). A final letter goes on
// to S_CREAD (count read) and S_CUPD (count update, held while a pending
// result is stalled), whose result is registered onto rsp. A new letter is
// accepted only in S_IDLE. Reset: a clearing pass zeroes both stores one row
// a cycle; req_stall stays high until it completes.
module trie_word_counter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  twc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output twc_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_CREAD,
      S_CUPD
   } state_type;

   state_type                      state_ff, state_in;
   twc_pkg::req_type               item_ff, item_in;
   twc_pkg::node_type              cur_ff, cur_in;
   logic [twc_pkg::USED_W-1:0]     used_ff, used_in;
   logic                           miss_ff, miss_in;
   logic                           ovf_ff, ovf_in;
   twc_pkg::node_type              clr_ff, clr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   twc_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                           req_accept;
   twc_pkg::child_row_type         child_rd;
   logic [twc_pkg::COUNT_W-1:0]    count_rd;
   twc_pkg::child_wr_type          child_wr;
   twc_pkg::count_wr_type          count_wr;
   twc_pkg::lane_type              lane;
   twc_pkg::node_type              child;
   logic                           in_range;
   logic                           pool_full;
   logic                           alloc;
   logic                           rsp_load;
   logic [twc_pkg::COUNT_W-1:0]    cnt;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign lane      = twc_pkg::LANE_W'(item_ff.letter);
   assign in_range  = (int'(item_ff.letter) < twc_pkg::ALPHABET);
   assign child     = in_range ? child_rd[lane] : '0;
   assign pool_full = (used_ff == twc_pkg::USED_W'(twc_pkg::NODES));
   assign alloc     = (state_ff == S_LOOK) && !miss_ff && in_range && (child == '0)
                      && (item_ff.func == twc_pkg::FUNC_INSERT) && !pool_full;
   assign rsp_load  = (state_ff == S_CUPD) && (!rsp_valid_ff || !rsp_stall);

   // Count reported at the end node, or zero off the trie; an insert reports the saturated increment.
   always_comb begin
      if (miss_ff) begin
         cnt = '0;
      end else if (item_ff.func == twc_pkg::FUNC_QUERY || count_rd == twc_pkg::COUNT_MAX) begin
         cnt = count_rd;
      end else begin
         cnt = twc_pkg::COUNT_W'(count_rd + 1'b1);
      end
   end

   always_comb begin
      child_wr = '0;
      if (state_ff == S_CLEAR) begin
         child_wr.en    = 1'b1;
         child_wr.clear = 1'b1;
         child_wr.row   = clr_ff;
      end else if (alloc) begin
         child_wr.en   = 1'b1;
         child_wr.row  = cur_ff;
         child_wr.lane = lane;
         child_wr.data = used_ff[twc_pkg::NODE_W-1:0];
      end
   end

   always_comb begin
      count_wr = '0;
      if (state_ff == S_CLEAR) begin
         count_wr.en   = 1'b1;
         count_wr.addr = clr_ff;
      end else if (rsp_load && !miss_ff && item_ff.func == twc_pkg::FUNC_INSERT) begin
         count_wr.en   = 1'b1;
         count_wr.addr = cur_ff;
         count_wr.data = cnt;
      end
   end

   twc_child_mem u_child_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_row  (cur_ff),
      .rd_data (child_rd),
      .wr      (child_wr)
   );

   twc_count_mem u_count_mem (
      .clock   (clock),
      .rd_en   (state_ff == S_CREAD),
      .rd_addr (cur_ff),
      .rd_data (count_rd),
      .wr      (count_wr)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      used_in      = used_ff;
      miss_in      = miss_ff;
      ovf_in       = ovf_ff;
      clr_in       = clr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == twc_pkg::NODE_W'(twc_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // Once the walk has left the trie, the rest of the word is ignored.
            if (!miss_ff) begin
               if (!in_range) begin
                  miss_in = 1'b1;
               end else if (child != '0) begin
                  cur_in = child;
               end else if (item_ff.func == twc_pkg::FUNC_QUERY) begin
                  miss_in = 1'b1;
               end else if (pool_full) begin
                  miss_in = 1'b1;
                  ovf_in  = 1'b1;
               end else begin
                  cur_in  = used_ff[twc_pkg::NODE_W-1:0];
                  used_in = used_ff + 1'b1;
               end
            end
            state_in = item_ff.last ? S_CREAD : S_IDLE;
         end
         S_CREAD: begin
            state_in = S_CUPD;
         end
         S_CUPD: begin
            if (rsp_load) begin
               rsp_data_in.count  = cnt;
               rsp_data_in.status = (item_ff.func == twc_pkg::FUNC_INSERT) && ovf_ff;
               rsp_valid_in       = 1'b1;
               cur_in             = '0;
               miss_in            = 1'b0;
               ovf_in             = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= '0;
         used_ff      <= twc_pkg::USED_W'(1);
         miss_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         miss_ff      <= miss_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= twc_pkg::USED_W'(twc_pkg::NODES))
      else $error("node pool count exceeds pool size");

   a_link_nonroot: assert property (@(posedge clock) disable iff (reset)
      child_wr.en && !child_wr.clear |-> child_wr.data != '0)
      else $error("child link written with the root node");

   a_alloc_bump: assert property (@(posedge clock) disable iff (reset)
      child_wr.en && !child_wr.clear |=> used_ff == $past(used_ff) + 1'b1)
      else $error("allocation did not advance the pool count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CUPD)
      else $error("result raised outside the count update step");
`endif

endmodule

@@ bench/trie_word_counter_tb.sv @@
// ----------------------------------------------------------------------------
// trie_word_counter_tb
// Self-checking bench for the trie word counter. Words are sent one letter
// per transaction. A scoreboard keeps its own trie and predicts the count and
// pool status of every finished word, then compares each returned result in
// order. The run covers directed corner words, a back-to-back run of repeats
// of one word, a random mix, a fill phase that runs the node pool out, and a
// short random mix on the full pool.
// ----------------------------------------------------------------------------
module trie_word_counter_tb;

   localparam int MAX_LEN      = 16;
   localparam int MIX_ITEMS    = 700;
   localparam int ITEM_CAP     = 4000;
   localparam int REPEAT_WORDS = 40;
   localparam int CHECK_WORDS  = 20;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AFTER   = 20;
   localparam int TAIL_CYCLES  = 20;
   localparam int DICT_SIZE    = 256;

   localparam logic [MAX_LEN-1:0] ALL_INSERT = {MAX_LEN{twc_pkg::FUNC_INSERT}};
   localparam logic [MAX_LEN-1:0] ALL_QUERY  = {MAX_LEN{twc_pkg::FUNC_QUERY}};

   typedef struct packed {
      logic [4:0]                                 len;
      logic [MAX_LEN-1:0][twc_pkg::LETTER_W-1:0] letters;
   } word_type;

   // Keeps a private trie and the queue of counts still owed by the block.
   class trie_checker;
      twc_pkg::node_type           child_link[twc_pkg::NODES*twc_pkg::ALPHABET];
      logic [twc_pkg::COUNT_W-1:0] word_total[twc_pkg::NODES];
      int unsigned                 nodes_taken;
      twc_pkg::node_type           walk_node;
      bit                          off_trie;
      bit                          word_overflow;
      twc_pkg::rsp_type            owed_counts[$];
      int                          failures;
      int                          matched;
      int                          overflow_words;

      function new();
         foreach (child_link[i]) child_link[i] = '0;
         foreach (word_total[i]) word_total[i] = '0;
         nodes_taken = 1;
         walk_node = '0;
         off_trie = 1'b0;
         word_overflow = 1'b0;
      endfunction

      function void take_letter(twc_pkg::req_type r);
         twc_pkg::rsp_type  want;
         int unsigned       slot;
         twc_pkg::node_type next;
         if (!off_trie) begin
            if (r.letter >= twc_pkg::ALPHABET) begin
               off_trie = 1'b1;
            end else begin
               slot = walk_node * twc_pkg::ALPHABET + r.letter;
               next = child_link[slot];
               if (next == '0) begin
                  if (r.func == twc_pkg::FUNC_QUERY) begin
                     off_trie = 1'b1;
                  end else if (nodes_taken >= twc_pkg::NODES) begin
                     off_trie = 1'b1;
                     word_overflow = 1'b1;
                  end else begin
                     next = twc_pkg::node_type'(nodes_taken);
                     nodes_taken++;
                     child_link[slot] = next;
                     walk_node = next;
                  end
               end else begin
                  walk_node = next;
               end
            end
         end
         if (r.last) begin
            want.count = '0;
            want.status = 1'b0;
            if (!off_trie) begin
               want.count = word_total[walk_node];
               if (r.func == twc_pkg::FUNC_INSERT) begin
                  if (want.count != twc_pkg::COUNT_MAX) want.count++;
                  word_total[walk_node] = want.count;
               end
            end
            if (r.func == twc_pkg::FUNC_INSERT && word_overflow) begin
               want.status = 1'b1;
               overflow_words++;
            end
            owed_counts.push_back(want);
            walk_node = '0;
            off_trie = 1'b0;
            word_overflow = 1'b0;
         end
      endfunction

      function void match_count(twc_pkg::rsp_type got);
         twc_pkg::rsp_type want;
         if (owed_counts.size() == 0) begin
            $error("result with no word pending: count %0d, status %0d",
                   got.count, got.status);
            failures++;
            return;
         end
         want = owed_counts.pop_front();
         if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, got.count);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         matched++;
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   twc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   twc_pkg::rsp_type rsp_data;

   trie_checker word_book;
   bit          idle_on = 1'b1;
   int          letters_sent;
   int          results_seen;
   int          quiet_cycles;
   word_type    dictionary[$];

   trie_word_counter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) word_book.take_letter(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         word_book.match_count(rsp_data);
         results_seen++;
      end
   end

   // Ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no transaction for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold so the block backs up.
   initial begin
      int hold;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && results_seen >= HOLD_AFTER) begin
            hold = HOLD_CYCLES;
            held = 1'b1;
         end else begin
            hold = idle_on ? $urandom_range(0, 12) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   task automatic send_letter(input twc_pkg::req_type item);
      int gap;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      letters_sent++;
   endtask

   task automatic send_word(input word_type w, input logic [MAX_LEN-1:0] funcs);
      twc_pkg::req_type item;
      for (int i = 0; i < w.len; i++) begin
         item.func = funcs[i];
         item.letter = w.letters[i];
         item.last = (i == w.len - 1);
         send_letter(item);
      end
   endtask

   function automatic word_type spell(input int n, input int a, input int b = 0,
                                      input int c = 0);
      word_type w;
      w = '0;
      w.len = 5'(n);
      w.letters[0] = twc_pkg::LETTER_W'(a);
      w.letters[1] = twc_pkg::LETTER_W'(b);
      w.letters[2] = twc_pkg::LETTER_W'(c);
      return w;
   endfunction

   function automatic word_type random_word(input int min_len);
      word_type w;
      w = '0;
      w.len = 5'($urandom_range(min_len, MAX_LEN));
      for (int i = 0; i < w.len; i++) begin
         w.letters[i] = twc_pkg::LETTER_W'($urandom_range(0, twc_pkg::ALPHABET - 1));
      end
      return w;
   endfunction

   // One word of the random mix: fresh inserts, repeats, queries, prefixes,
   // mixed selectors and letters past the alphabet.
   task automatic send_mixed_word();
      word_type           w;
      logic [MAX_LEN-1:0] funcs;
      int                 pick;
      int                 pos;
      if (letters_sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (dictionary.size() == 0 || pick < 45) begin
         w = random_word(1);
         funcs = ALL_INSERT;
         if (dictionary.size() < DICT_SIZE) dictionary.push_back(w);
         else dictionary[$urandom_range(0, DICT_SIZE - 1)] = w;
      end else begin
         w = dictionary[$urandom_range(0, dictionary.size() - 1)];
         funcs = (pick < 70) ? ALL_INSERT : ALL_QUERY;
         if (pick >= 85 && pick < 90) begin
            w = random_word(1);
            funcs = ALL_QUERY;
         end else if (pick >= 90 && pick < 94) begin
            w.len = 5'($urandom_range(1, w.len));
            funcs = $urandom_range(0, 1) ? ALL_QUERY : ALL_INSERT;
         end else if (pick >= 94 && pick < 97) begin
            funcs = MAX_LEN'($urandom);
         end else if (pick >= 97) begin
            pos = $urandom_range(0, w.len - 1);
            w.letters[pos] = twc_pkg::LETTER_W'($urandom_range(twc_pkg::ALPHABET, 31));
            funcs = $urandom_range(0, 1) ? ALL_QUERY : ALL_INSERT;
         end
      end
      send_word(w, funcs);
   endtask

   initial begin
      word_book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed words: first and last letters, repeats, absent paths,
      // letters past the alphabet and a selector that changes mid-word.
      send_word(spell(1, 0), ALL_INSERT);
      send_word(spell(1, 0), ALL_INSERT);
      send_word(spell(1, 0), ALL_QUERY);
      send_word(spell(1, 25), ALL_INSERT);
      send_word(spell(2, 0, 1), ALL_INSERT);
      send_word(spell(1, 1), ALL_QUERY);
      send_word(spell(3, 0, 1, 25), ALL_QUERY);
      send_word(spell(1, 31), ALL_INSERT);
      send_word(spell(2, 2, twc_pkg::ALPHABET), ALL_INSERT);
      send_word(spell(1, 31), ALL_QUERY);
      send_word(spell(2, 0, 1), {{(MAX_LEN-2){twc_pkg::FUNC_INSERT}},
                                 twc_pkg::FUNC_QUERY, twc_pkg::FUNC_INSERT});
      send_word(spell(2, 0, 2), {{(MAX_LEN-2){twc_pkg::FUNC_INSERT}},
                                 twc_pkg::FUNC_INSERT, twc_pkg::FUNC_QUERY});
      send_word(spell(2, 16, 16), ALL_INSERT);

      // Repeat one word back to back without idling.
      idle_on = 1'b0;
      repeat (REPEAT_WORDS) send_word(spell(1, 16), ALL_INSERT);
      send_word(spell(1, 16), ALL_QUERY);
      idle_on = 1'b1;

      while (letters_sent < MIX_ITEMS) send_mixed_word();

      // Long fresh words use up the node pool until an insert overflows.
      while (word_book.overflow_words == 0 && letters_sent < ITEM_CAP) begin
         send_word(random_word(MAX_LEN), ALL_INSERT);
      end

      repeat (CHECK_WORDS) send_mixed_word();
      req_valid <= 1'b0;

      while (word_book.owed_counts.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d letters; %0d word results checked, %0d nodes allocated.",
               letters_sent, word_book.matched, word_book.nodes_taken);
      $display("%0d words hit a full pool after random, repeated and long words.",
               word_book.overflow_words);
      if (word_book.failures == 0 && word_book.owed_counts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ trie_word_counter.f @@
rtl/twc_pkg.sv
rtl/twc_child_mem.sv
rtl/twc_count_mem.sv
rtl/trie_word_counter.sv
bench/trie_word_counter_tb.sv
